// ----- hdl/deadline_timer_min_heap_defines.svh -----
// assertion macros for the checker file
`ifndef DEADLINE_TIMER_MIN_HEAP_DEFINES_SVH
`define DEADLINE_TIMER_MIN_HEAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define DTMH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define DTMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dtmh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmh_pkg
// shared constants, codes and control types of the deadline timer heap
// ----------------------------------------------------------------------------
package dtmh_pkg;

  localparam int MAX_TIMERS_DEF = 16;
  localparam int NUM_IDS        = 16;
  localparam int ID_W           = 4;
  localparam int US_W           = 32;
  localparam int DL_W           = 64;
  localparam int PERIOD_W       = 42;
  localparam int COUNT_W        = 5;
  localparam int MAX_RESULTS    = 16;
  localparam int FCNT_W         = 5;
  localparam int FIDX_W         = 4;
  localparam int IN_TDATA_W     = 104;
  localparam int OUT_TDATA_W    = 80;
  localparam int ENTRY_W        = DL_W + ID_W;

  localparam logic [PERIOD_W-1:0] NS_PER_US = PERIOD_W'(1000);

  localparam logic [1:0] CMD_ARM    = 2'd0;
  localparam logic [1:0] CMD_DISARM = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_LOAD, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
    S_PLACE, S_RUN_RD, S_RUN_CMP, S_FIN_RD, S_FIN, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_ARM_OLD, OP_ARM_NEW, OP_ARM_FULL, OP_DIS_MOVE,
    OP_DIS_TAIL, OP_LOAD, OP_UP_SWAP, OP_DN_SWAP, OP_PLACE, OP_FIRE,
    OP_ROOT, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_PARENT, RD_CHILD, RD_ROOT, RD_TAIL
  } rd_sel_t;

  typedef struct packed {
    op_t     op;
    rd_sel_t rd;
  } dtmh_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       armed;
    logic       full;
    logic       dis_move;
    logic       pos_zero;
    logic       moved;
    logic       up_swap;
    logic       l_out;
    logic       dn_swap;
    logic       size_zero;
    logic       fcount_max;
    logic       run_fire;
    logic       emit_last;
  } dtmh_stat_t;

endpackage

// ----- hdl/dtmh_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmh_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module dtmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra,
  input  logic [$clog2(DEPTH)-1:0] rb,
  output logic [WIDTH-1:0]         qa,
  output logic [WIDTH-1:0]         qb
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

// ----- hdl/dtmh_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmh_ctrl
// sequencer for arm, disarm, run and result delivery
// ----------------------------------------------------------------------------
module dtmh_ctrl
  import dtmh_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dtmh_stat_t stat,
  output dtmh_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (stat.cmd)
          CMD_ARM: begin
            if (stat.armed || !stat.full) state_next = S_UP_RD;
            else state_next = S_FIN_RD;
          end
          CMD_DISARM: begin
            if (stat.armed && stat.dis_move) state_next = S_LOAD;
            else state_next = S_FIN_RD;
          end
          CMD_RUN: state_next = S_RUN_RD;
          default: state_next = S_FIN_RD;
        endcase
      end
      S_LOAD:   state_next = S_UP_RD;
      S_UP_RD: begin
        if (!stat.pos_zero) state_next = S_UP_CMP;
        else if (stat.moved) state_next = S_PLACE;
        else state_next = S_DN_RD;
      end
      S_UP_CMP: begin
        if (stat.up_swap) state_next = S_UP_RD;
        else if (stat.moved) state_next = S_PLACE;
        else state_next = S_DN_RD;
      end
      S_DN_RD:  state_next = stat.l_out ? S_PLACE : S_DN_CMP;
      S_DN_CMP: state_next = stat.dn_swap ? S_DN_RD : S_PLACE;
      S_PLACE:  state_next = (stat.cmd == CMD_RUN) ? S_RUN_RD : S_FIN_RD;
      S_RUN_RD: state_next = (stat.size_zero || stat.fcount_max) ? S_FIN_RD : S_RUN_CMP;
      S_RUN_CMP: state_next = stat.run_fire ? S_DN_RD : S_FIN_RD;
      S_FIN_RD: state_next = S_FIN;
      S_FIN:    state_next = S_EMIT;
      S_EMIT:   if (out_ready && stat.emit_last) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.rd    = RD_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_DECODE: begin
        case (stat.cmd)
          CMD_ARM: begin
            if (stat.armed) cmd.op = OP_ARM_OLD;
            else if (stat.full) cmd.op = OP_ARM_FULL;
            else cmd.op = OP_ARM_NEW;
          end
          CMD_DISARM: begin
            if (stat.armed && stat.dis_move) begin
              cmd.op = OP_DIS_MOVE;
              cmd.rd = RD_TAIL;
            end else if (stat.armed) begin
              cmd.op = OP_DIS_TAIL;
            end
          end
          default: cmd.op = OP_NONE;
        endcase
      end
      S_LOAD:    cmd.op = OP_LOAD;
      S_UP_RD:   if (!stat.pos_zero) cmd.rd = RD_PARENT;
      S_UP_CMP:  if (stat.up_swap) cmd.op = OP_UP_SWAP;
      S_DN_RD:   if (!stat.l_out) cmd.rd = RD_CHILD;
      S_DN_CMP:  if (stat.dn_swap) cmd.op = OP_DN_SWAP;
      S_PLACE:   cmd.op = OP_PLACE;
      S_RUN_RD:  if (!(stat.size_zero || stat.fcount_max)) cmd.rd = RD_ROOT;
      S_RUN_CMP: if (stat.run_fire) cmd.op = OP_FIRE;
      S_FIN_RD:  cmd.rd = RD_ROOT;
      S_FIN:     cmd.op = OP_ROOT;
      S_EMIT: begin
        out_valid = 1'b1;
        cmd.op    = OP_EMIT;
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- hdl/dtmh_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmh_dp
// heap storage, timer tables, sift datapath and result buffer
// ----------------------------------------------------------------------------
module dtmh_dp
  import dtmh_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dtmh_cmd_t          cmd,
  output dtmh_stat_t         stat,
  input  logic               out_ready,
  input  logic [1:0]         in_command,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [US_W-1:0]    in_period_us,
  input  logic [DL_W-1:0]    in_now_ns,
  output logic               status,
  output logic               fired,
  output logic [ID_W-1:0]    fired_timer,
  output logic [DL_W-1:0]    next_deadline,
  output logic [COUNT_W-1:0] armed_count,
  output logic               last
);

  localparam int IW = $clog2(MAX_TIMERS);
  localparam int SW = $clog2(MAX_TIMERS + 1);
  localparam int CW = IW + 2;

  logic [1:0]          cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [DL_W-1:0]     now_r;
  logic [PERIOD_W-1:0] per_r;
  logic                status_r;
  logic [DL_W-1:0]     cur_dl;
  logic [ID_W-1:0]     cur_own;
  logic [IW-1:0]       pos;
  logic                moved;
  logic [SW-1:0]       size;
  logic [NUM_IDS-1:0]  armed;
  logic [IW-1:0]       slot [NUM_IDS];
  logic [PERIOD_W-1:0] period [NUM_IDS];
  logic [ID_W-1:0]     fifo [MAX_RESULTS];
  logic [FCNT_W-1:0]   fcount;
  logic [FIDX_W-1:0]   idx;
  logic [DL_W-1:0]     root_r;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [ENTRY_W-1:0]  wdata;
  logic [IW-1:0]       ra, rb;
  logic [ENTRY_W-1:0]  qa, qb;
  logic [DL_W-1:0]     qa_dl, qb_dl;
  logic [ID_W-1:0]     qa_own, qb_own;

  logic [CW-1:0]       l_ext, r_ext;
  logic [IW-1:0]       parent;
  logic [IW-1:0]       slot_id;
  logic                r_ok;
  logic                pick_l, pick_r;
  logic [DL_W-1:0]     best_dl;
  logic [ENTRY_W-1:0]  best_q;
  logic [IW-1:0]       best_pos;
  logic [DL_W-1:0]     arm_dl;
  logic [DL_W-1:0]     fire_dl;

  dtmh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TIMERS)
  ) u_heap (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .ra    (ra),
    .rb    (rb),
    .qa    (qa),
    .qb    (qb)
  );

  assign qa_dl  = qa[DL_W-1:0];
  assign qa_own = qa[ENTRY_W-1:DL_W];
  assign qb_dl  = qb[DL_W-1:0];
  assign qb_own = qb[ENTRY_W-1:DL_W];

  assign l_ext   = {1'b0, pos, 1'b1};
  assign r_ext   = l_ext + CW'(1);
  assign parent  = IW'((pos - IW'(1)) >> 1);
  assign slot_id = slot[id_r];
  assign r_ok    = r_ext < CW'(size);
  assign arm_dl  = now_r + DL_W'(per_r);
  assign fire_dl = now_r + DL_W'(period[qa_own]);

  // smaller child, ties to the left
  always_comb begin
    pick_l   = qa_dl < cur_dl;
    best_dl  = pick_l ? qa_dl : cur_dl;
    pick_r   = r_ok && (qb_dl < best_dl);
    best_q   = pick_r ? qb : qa;
    best_pos = pick_r ? r_ext[IW-1:0] : l_ext[IW-1:0];
  end

  always_comb begin
    case (cmd.rd)
      RD_PARENT: ra = parent;
      RD_CHILD:  ra = l_ext[IW-1:0];
      RD_TAIL:   ra = IW'(size - SW'(1));
      default:   ra = '0;
    endcase
    rb = r_ext[IW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = {cur_own, cur_dl};
    case (cmd.op)
      OP_UP_SWAP: begin
        we    = 1'b1;
        wdata = qa;
      end
      OP_DN_SWAP: begin
        we    = 1'b1;
        wdata = best_q;
      end
      OP_PLACE:   we = 1'b1;
      default:    we = 1'b0;
    endcase
  end

  always_comb begin
    stat.cmd        = cmd_r;
    stat.armed      = armed[id_r];
    stat.full       = CW'(size) >= CW'(MAX_TIMERS);
    stat.dis_move   = ({2'b00, slot_id} + CW'(1)) < CW'(size);
    stat.pos_zero   = pos == '0;
    stat.moved      = moved;
    stat.up_swap    = qa_dl > cur_dl;
    stat.l_out      = l_ext >= CW'(size);
    stat.dn_swap    = pick_l || pick_r;
    stat.size_zero  = size == '0;
    stat.fcount_max = fcount == FCNT_W'(MAX_RESULTS);
    stat.run_fire   = (qa_dl != '0) && (qa_dl < now_r);
    stat.emit_last  = (fcount == '0) || ({1'b0, idx} == fcount - FCNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size   <= '0;
      armed  <= '0;
      fcount <= '0;
      idx    <= '0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          fcount <= '0;
          idx    <= '0;
        end
        OP_ARM_NEW: begin
          armed[id_r] <= 1'b1;
          size        <= size + SW'(1);
        end
        OP_DIS_MOVE, OP_DIS_TAIL: begin
          armed[id_r] <= 1'b0;
          size        <= size - SW'(1);
        end
        OP_FIRE:   fcount <= fcount + FCNT_W'(1);
        OP_EMIT:   if (out_ready) idx <= idx + FIDX_W'(1);
        default:   idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        cmd_r    <= in_command;
        id_r     <= in_timer_id;
        now_r    <= in_now_ns;
        per_r    <= PERIOD_W'(in_period_us) * NS_PER_US;
        status_r <= 1'b0;
        moved    <= 1'b0;
      end
      OP_ARM_OLD: begin
        period[id_r] <= per_r;
        cur_dl       <= arm_dl;
        cur_own      <= id_r;
        pos          <= slot_id;
      end
      OP_ARM_NEW: begin
        period[id_r] <= per_r;
        cur_dl       <= arm_dl;
        cur_own      <= id_r;
        pos          <= size[IW-1:0];
      end
      OP_ARM_FULL: status_r <= 1'b1;
      OP_DIS_MOVE: pos <= slot_id;
      OP_LOAD: begin
        cur_dl  <= qa_dl;
        cur_own <= qa_own;
      end
      OP_UP_SWAP: begin
        slot[qa_own] <= pos;
        pos          <= parent;
        moved        <= 1'b1;
      end
      OP_DN_SWAP: begin
        slot[best_q[ENTRY_W-1:DL_W]] <= pos;
        pos                          <= best_pos;
      end
      OP_PLACE:   slot[cur_own] <= pos;
      OP_FIRE: begin
        cur_dl                    <= fire_dl;
        cur_own                   <= qa_own;
        pos                       <= '0;
        moved                     <= 1'b0;
        fifo[fcount[FIDX_W-1:0]]  <= qa_own;
      end
      OP_ROOT:    root_r <= (size == '0) ? '0 : qa_dl;
      default:    root_r <= root_r;
    endcase
  end

  assign status        = status_r;
  assign fired         = fcount != '0;
  assign fired_timer   = (fcount != '0) ? fifo[idx] : '0;
  assign next_deadline = root_r;
  assign armed_count   = COUNT_W'(size);
  assign last          = stat.emit_last;

endmodule

// ----- hdl/deadline_timer_min_heap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_min_heap
// periodic timer scheduler on a binary min-heap of nanosecond deadlines
// ----------------------------------------------------------------------------
// One request at a time: arm (command 0) sets a timer's period to
// period_us*1000 ns and its deadline to now_ns+period, sifting it into the
// heap; disarm (command 1) pulls a timer out and refills its slot with the
// tail entry; run (command 2) fires the root timer while its deadline
// is nonzero and below now_ns, up to sixteen, re-arming each at
// now_ns+period. Each request gives one result, or one per fired timer for
// run, and every result of a request carries the heap minimum and size
// after the whole request. The sift sequencer moves an entry one heap level
// per read state and compare state, through a ram with a registered read;
// an arm or a disarm that places an entry repeats that pair of states for
// each level the entry moves, and a run repeats the sift per fired timer.
// A new request is taken only after the last result of the previous one
// has been taken downstream.
module deadline_timer_min_heap
  import dtmh_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // command[1:0], timer_id[5:2], period_us[37:6], now_ns[101:38], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // result channel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[0], fired_timer[4:1], next_deadline[68:5], armed_count[73:69], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // fired[0]
  output logic                   m_axis_tuser,
  // last result of the request
  output logic                   m_axis_tlast
);

  dtmh_cmd_t  cmd;
  dtmh_stat_t stat;

  logic               status;
  logic               fired;
  logic [ID_W-1:0]    fired_timer;
  logic [DL_W-1:0]    next_deadline;
  logic [COUNT_W-1:0] armed_count;
  logic               last;

  // sequencer: decode, sift steps, run loop, result delivery
  dtmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // heap ram, per-timer tables, comparators and fired-id buffer
  dtmh_dp #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (m_axis_tready),
    .in_command    (s_axis_tdata[1:0]),
    .in_timer_id   (s_axis_tdata[5:2]),
    .in_period_us  (s_axis_tdata[37:6]),
    .in_now_ns     (s_axis_tdata[101:38]),
    .status        (status),
    .fired         (fired),
    .fired_timer   (fired_timer),
    .next_deadline (next_deadline),
    .armed_count   (armed_count),
    .last          (last)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {6'b0, armed_count, next_deadline, fired_timer, status};
  assign m_axis_tuser = fired;
  assign m_axis_tlast = last;

endmodule

// ----- hdl/dtmh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmh_checker
// port-level checks of the timer heap, bound to the top level
// ----------------------------------------------------------------------------
`include "deadline_timer_min_heap_defines.svh"

module dtmh_checker
  import dtmh_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // a stalled result holds
  `DTMH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // no new request while results of the previous one are pending
  `DTMH_ASSERT_NOW(a_one_at_a_time, m_axis_tvalid, !s_axis_tready, "request taken during delivery")

  // a fired result never reports a rejected arm
  `DTMH_ASSERT_NOW(a_fired_ok, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0], "fired result with full status")

  // a fired timer is re-armed, so the heap cannot be empty; checked before the last result
  `DTMH_ASSERT_NOW(a_fired_nonempty, m_axis_tvalid && m_axis_tuser && !m_axis_tlast, m_axis_tdata[73:69] != 5'd0, "fired with empty heap")

endmodule

bind deadline_timer_min_heap dtmh_checker u_dtmh_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the deadline timer heap
// ----------------------------------------------------------------------------
// Requests come first from a short table: the empty-heap cases, the wrap of
// the deadline sum, a zero deadline at the root, a full heap of sixteen and
// a run that fires all of them. Random arm, disarm, run and unused requests
// follow, over a slowly advancing clock so that runs really fire. A
// behavioral heap in the bench predicts the results of every row that is not
// typed by hand, and results are checked in order as they leave the block.
// Both sides idle at random, in phases.
// ----------------------------------------------------------------------------
module tb_top;
  import dtmh_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [3:0]  fired_timer;
    logic [63:0] next_deadline;
    logic [4:0]  armed_count;
    logic        last;
  } timer_result_t;

  typedef struct {
    logic [1:0]    cmd;
    logic [3:0]    id;
    logic [31:0]   us;
    logic [63:0]   now;
    bit            typed;     // expected result written out by hand
    timer_result_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  always #6 clk = ~clk;

  deadline_timer_min_heap dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  // behavioral copy of the heap
  logic [63:0] heap_dl [16];
  logic [3:0]  heap_who [16];
  int unsigned slot_of [16];
  bit          is_armed [16];
  logic [63:0] period_ns [16];
  int unsigned heap_n;

  timer_result_t pending_results[$];
  timer_result_t step_results[$];
  int errors = 0;
  int tx_idle = 0;
  int rx_stall = 0;
  int cycles = 0;

  function automatic void put_entry(int unsigned p, logic [63:0] dl, logic [3:0] who);
    heap_dl[p] = dl;
    heap_who[p] = who;
    slot_of[who] = p;
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [63:0] d;
    logic [3:0] w;
    d = heap_dl[a];
    w = heap_who[a];
    put_entry(a, heap_dl[b], heap_who[b]);
    put_entry(b, d, w);
  endfunction

  function automatic void bubble_up(int unsigned p);
    int unsigned up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (!(heap_dl[up] > heap_dl[p])) break;
      swap_entries(up, p);
      p = up;
    end
  endfunction

  function automatic void push_down(int unsigned p);
    int unsigned l, best;
    logic [63:0] bd;
    forever begin
      l = 2 * p + 1;
      best = p;
      bd = heap_dl[p];
      if (l >= heap_n) break;
      if (heap_dl[l] < bd) begin
        best = l;
        bd = heap_dl[l];
      end
      // ties stay with the left child
      if (l + 1 < heap_n && heap_dl[l + 1] < bd) best = l + 1;
      if (best == p) break;
      swap_entries(p, best);
      p = best;
    end
  endfunction

  function automatic void reorder_at(int unsigned p);
    if (p >= heap_n) return;
    if (p > 0 && heap_dl[p] < heap_dl[(p - 1) / 2]) bubble_up(p);
    else push_down(p);
  endfunction

  function automatic logic [63:0] heap_min();
    return (heap_n != 0) ? heap_dl[0] : 64'd0;
  endfunction

  // works out the results of one request and updates the heap copy
  function automatic void predict_timer_step(logic [1:0] cmd, logic [3:0] id,
                                             logic [31:0] us, logic [63:0] now);
    timer_result_t r;
    logic [63:0] per, m;
    logic [3:0] who;
    logic st;
    int unsigned at, tail;
    st = 1'b0;
    step_results.delete();
    per = 64'(us) * 64'd1000;
    case (cmd)
      CMD_ARM: begin
        if (is_armed[id]) begin
          period_ns[id] = per;
          heap_dl[slot_of[id]] = now + per;
          reorder_at(slot_of[id]);
        end else if (heap_n >= 16) begin
          st = 1'b1;
        end else begin
          period_ns[id] = per;
          is_armed[id] = 1'b1;
          put_entry(heap_n, now + per, id);
          heap_n++;
          bubble_up(heap_n - 1);
        end
      end
      CMD_DISARM: begin
        if (is_armed[id] && heap_n > 0) begin
          at = slot_of[id];
          is_armed[id] = 1'b0;
          if (at + 1 < heap_n) begin
            tail = heap_n - 1;
            put_entry(at, heap_dl[tail], heap_who[tail]);
            heap_n--;
            reorder_at(at);
          end else begin
            heap_n--;
          end
        end
      end
      CMD_RUN: begin
        while (step_results.size() < 16) begin
          m = heap_min();
          // a zero minimum reads as an empty heap
          if (m == 64'd0 || !(m < now)) break;
          who = heap_who[0];
          heap_dl[0] = now + period_ns[who];
          reorder_at(0);
          r = '0;
          r.fired = 1'b1;
          r.fired_timer = who;
          step_results.push_back(r);
        end
      end
      default: ;
    endcase
    if (step_results.size() == 0) begin
      r = '0;
      r.status = st;
      step_results.push_back(r);
    end
    foreach (step_results[k]) begin
      step_results[k].next_deadline = heap_min();
      step_results[k].armed_count = 5'(heap_n);
      step_results[k].last = (k == step_results.size() - 1);
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result side: random stall and in-order check
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[0] !== want.status)
            report_mismatch("status", m_axis_tdata[0], want.status);
          if (m_axis_tuser !== want.fired)
            report_mismatch("fired", m_axis_tuser, want.fired);
          if (m_axis_tdata[4:1] !== want.fired_timer)
            report_mismatch("fired_timer", m_axis_tdata[4:1], want.fired_timer);
          if (m_axis_tdata[68:5] !== want.next_deadline)
            report_mismatch("next_deadline", m_axis_tdata[68:5], want.next_deadline);
          if (m_axis_tdata[73:69] !== want.armed_count)
            report_mismatch("armed_count", m_axis_tdata[73:69], want.armed_count);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", m_axis_tlast, want.last);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // one request through the handshake, then into the predictor
  task automatic send_request(logic [1:0] cmd, logic [3:0] id, logic [31:0] us,
                              logic [63:0] now, bit typed, timer_result_t res);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b0, now, us, id, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_timer_step(cmd, id, us, now);
    if (typed) pending_results.push_back(res);
    else foreach (step_results[k]) pending_results.push_back(step_results[k]);
  endtask

  // sender holds off until the block has nothing outstanding
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  table_row_t directed[$];
  logic [63:0] clock_ns;

  initial begin
    table_row_t row;
    timer_result_t blank;
    logic [1:0] c;
    int pick;
    logic [31:0] us;
    logic [63:0] now;

    heap_n = 0;
    foreach (is_armed[i]) begin
      is_armed[i] = 1'b0;
      slot_of[i] = 0;
      period_ns[i] = '0;
    end

    // empty heap: run, disarm of an unarmed timer, unused command
    blank = '0;
    blank.last = 1'b1;
    directed.push_back('{CMD_RUN, 4'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1, blank});
    directed.push_back('{CMD_DISARM, 4'd7, 32'd0, 64'd0, 1, blank});
    directed.push_back('{CMD_NOP, 4'd15, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, blank});
    // deadline sum wraps past 2^64
    directed.push_back('{CMD_ARM, 4'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, blank});
    // zero deadline at the root, run then sees an empty heap
    directed.push_back('{CMD_ARM, 4'd15, 32'd0, 64'd0, 0, blank});
    directed.push_back('{CMD_RUN, 4'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0, blank});
    directed.push_back('{CMD_DISARM, 4'd15, 32'd0, 64'd0, 0, blank});
    directed.push_back('{CMD_DISARM, 4'd0, 32'd0, 64'd0, 0, blank});
    // fill all sixteen, then one run fires every one of them
    for (int i = 0; i < 16; i++)
      directed.push_back('{CMD_ARM, 4'(i), 32'(i % 3), 64'(1000 + 37 * ((i * 7) % 16)),
                           0, blank});
    directed.push_back('{CMD_RUN, 4'd0, 32'd0, 64'd100000, 0, blank});

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.cmd, row.id, row.us, row.now, row.typed, row.res);
    end
    drain_results();

    // random phases: sender idle / receiver stall percentages
    clock_ns = 64'd200000;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 52; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 52; end
        default: begin tx_idle = 18; rx_stall = 18; end
      endcase
      for (int n = 0; n < 59; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) c = CMD_ARM;
        else if (pick < 70) c = CMD_DISARM;
        else if (pick < 95) c = CMD_RUN;
        else c = CMD_NOP;
        us = ($urandom_range(99) < 85) ? 32'($urandom_range(20)) : 32'($urandom);
        clock_ns = clock_ns + 64'($urandom_range(20000));
        now = ($urandom_range(99) < 4) ? {$urandom, $urandom} : clock_ns;
        send_request(c, 4'($urandom_range(15)), us, now, 0, blank);
      end
      drain_results();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dtmh_pkg.sv
hdl/dtmh_ram.sv
hdl/dtmh_ctrl.sv
hdl/dtmh_dp.sv
hdl/deadline_timer_min_heap.sv
hdl/dtmh_checker.sv
tb/sv/tb_top.sv
